// ===== src/sclex_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, token and error codes, and character helpers for the lexer.
// Depends on nothing; used by sclex_ctrl, sclex_dp and source_char_lexer.
package sclex_pkg;

	// Token kinds
	localparam logic [3:0] KIND_NAME   = 4'd0;
	localparam logic [3:0] KIND_EXIT   = 4'd1;
	localparam logic [3:0] KIND_PRINT  = 4'd2;
	localparam logic [3:0] KIND_CONST  = 4'd3;
	localparam logic [3:0] KIND_INT    = 4'd4;
	localparam logic [3:0] KIND_STRING = 4'd5;
	localparam logic [3:0] KIND_SEMI   = 4'd6;
	localparam logic [3:0] KIND_POPEN  = 4'd7;
	localparam logic [3:0] KIND_PCLOSE = 4'd8;
	localparam logic [3:0] KIND_EQUAL  = 4'd9;
	localparam logic [3:0] KIND_NUMBER = 4'd10;
	localparam logic [3:0] KIND_TEXT   = 4'd11;

	// Error codes
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_UNKNOWN  = 3'd1;
	localparam logic [2:0] ERR_LINEBRK  = 3'd2;
	localparam logic [2:0] ERR_NO_QUOTE = 3'd3;
	localparam logic [2:0] ERR_TOO_LONG = 3'd4;

	localparam int NUM_KW = 5;

	typedef enum logic [3:0] {
		CC_SPACE,
		CC_CRLF,
		CC_LETTER,
		CC_DIGIT,
		CC_DASH,
		CC_QUOTE,
		CC_SEMI,
		CC_POPEN,
		CC_PCLOSE,
		CC_EQUAL,
		CC_OTHER
	} char_class_t;

	// One result word as requested by the controller
	typedef struct packed {
		logic       valid;
		logic [3:0] kind;
		logic       has_char;
		logic       token_last;
		logic [2:0] err;
		logic       run_last;
	} emit_t;

	typedef struct packed {
		logic  load_char;
		logic  append;
		logic  clear;
		logic  rd_start;
		logic  rd_next;
		emit_t emit;
	} dp_cmd_t;

	typedef struct packed {
		char_class_t cls;
		logic        full;
		logic        len_zero;
		logic        last_char;
		logic        kw_hit;
		logic [3:0]  kw_kind;
		logic        out_free;
	} dp_status_t;

	// Classify one source byte; CR and LF kept apart since quotes reject them
	function automatic char_class_t classify(logic [7:0] c);
		char_class_t r;
		if (c == 8'h0A || c == 8'h0D)
			r = CC_CRLF;
		else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))
			r = CC_SPACE;
		else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_")
			r = CC_LETTER;
		else if (c >= "0" && c <= "9")
			r = CC_DIGIT;
		else if (c == "-")
			r = CC_DASH;
		else if (c == 8'h22)
			r = CC_QUOTE;
		else if (c == ";")
			r = CC_SEMI;
		else if (c == "(")
			r = CC_POPEN;
		else if (c == ")")
			r = CC_PCLOSE;
		else if (c == "=")
			r = CC_EQUAL;
		else
			r = CC_OTHER;
		return r;
	endfunction

	// Keyword lengths: exit, print, const, int, string
	function automatic logic [2:0] kw_len(logic [2:0] k);
		logic [2:0] r;
		case (k)
			3'd0: r = 3'd4;
			3'd1: r = 3'd5;
			3'd2: r = 3'd5;
			3'd3: r = 3'd3;
			3'd4: r = 3'd6;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	// Keyword character at a position, left aligned in a six-byte word
	function automatic logic [7:0] kw_char(logic [2:0] k, logic [2:0] pos);
		logic [47:0] w;
		logic [7:0]  r;
		case (k)
			3'd0: w = {"exit", 16'h0000};
			3'd1: w = {"print", 8'h00};
			3'd2: w = {"const", 8'h00};
			3'd3: w = {"int", 24'h000000};
			3'd4: w = "string";
			default: w = 48'h0;
		endcase
		if (pos < 3'd6)
			r = w[47 - 8 * pos -: 8];
		else
			r = 8'h00;
		return r;
	endfunction

endpackage

// ===== src/sclex_dp.sv =====
`timescale 1ns / 1ps
// Lexer datapath: character register, token text memory, length and keyword
// match tracking, read pointer and output word register. Uses sclex_pkg.
module sclex_dp #(
	parameter int MAX_TOKEN_LEN = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            in_char,
	input  sclex_pkg::dp_cmd_t    cmd,
	output sclex_pkg::dp_status_t status,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [3:0]            out_kind,
	output logic                  out_has_char,
	output logic [7:0]            out_text_char,
	output logic [4:0]            out_char_index,
	output logic                  out_token_last,
	output logic [2:0]            out_error_code,
	output logic                  out_run_last
);
	import sclex_pkg::*;

	localparam int AW = (MAX_TOKEN_LEN > 1) ? $clog2(MAX_TOKEN_LEN) : 1;
	localparam int LW = $clog2(MAX_TOKEN_LEN + 1);

	logic [7:0]        char_q;
	logic [7:0]        mem_q [MAX_TOKEN_LEN];
	logic [7:0]        rdata_q;
	logic [AW-1:0]     rd_idx_q;
	logic [AW-1:0]     rd_addr;
	logic [LW-1:0]     len_q;
	logic [NUM_KW-1:0] kw_ok_q;
	logic [NUM_KW-1:0] kw_upd;
	logic              kw_hit;
	logic [3:0]        kw_kind;
	logic              out_free;

	logic              out_valid_q;
	logic [3:0]        kind_q;
	logic              has_q;
	logic [7:0]        text_q;
	logic [4:0]        idx_q;
	logic              tlast_q;
	logic [2:0]        err_q;
	logic              rlast_q;

	// Pick the read address so the next text word is ready when the current one leaves
	always_comb begin
		if (cmd.rd_start)
			rd_addr = '0;
		else if (cmd.rd_next)
			rd_addr = rd_idx_q + AW'(1);
		else
			rd_addr = rd_idx_q;
	end

	// Hold the input byte, write text, read with registered data
	always_ff @(posedge clk) begin
		if (cmd.load_char)
			char_q <= in_char;
		if (cmd.append)
			mem_q[len_q[AW-1:0]] <= char_q;
		rdata_q  <= mem_q[rd_addr];
		rd_idx_q <= rd_addr;
	end

	// Advance keyword match flags with each appended character
	always_comb begin
		for (int k = 0; k < NUM_KW; k++) begin
			kw_upd[k] = kw_ok_q[k] && (len_q < LW'(kw_len(3'(k))))
				&& (char_q == kw_char(3'(k), len_q[2:0]));
		end
	end

	// Resolve a keyword from the flags and the final length
	always_comb begin
		kw_hit  = 1'b0;
		kw_kind = KIND_NAME;
		for (int k = 0; k < NUM_KW; k++) begin
			if (kw_ok_q[k] && len_q == LW'(kw_len(3'(k)))) begin
				kw_hit  = 1'b1;
				kw_kind = 4'(k + 1);
			end
		end
	end

	// Track text length and keyword flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			kw_ok_q <= '1;
		end else if (cmd.clear) begin
			len_q   <= '0;
			kw_ok_q <= '1;
		end else if (cmd.append) begin
			len_q   <= len_q + LW'(1);
			kw_ok_q <= kw_upd;
		end
	end

	assign out_free = !out_valid_q || out_ready;

	// Hold the output word until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load output word fields
	always_ff @(posedge clk) begin
		if (cmd.emit.valid) begin
			kind_q  <= cmd.emit.kind;
			has_q   <= cmd.emit.has_char;
			text_q  <= cmd.emit.has_char ? rdata_q : 8'h00;
			idx_q   <= cmd.emit.has_char ? 5'(rd_idx_q) : 5'd0;
			tlast_q <= cmd.emit.token_last;
			err_q   <= cmd.emit.err;
			rlast_q <= cmd.emit.run_last;
		end
	end

	always_comb begin
		status.cls       = classify(char_q);
		status.full      = (len_q == LW'(MAX_TOKEN_LEN));
		status.len_zero  = (len_q == '0);
		status.last_char = ((LW'(rd_idx_q) + LW'(1)) == len_q);
		status.kw_hit    = kw_hit;
		status.kw_kind   = kw_kind;
		status.out_free  = out_free;
	end

	assign out_valid      = out_valid_q;
	assign out_kind       = kind_q;
	assign out_has_char   = has_q;
	assign out_text_char  = text_q;
	assign out_char_index = idx_q;
	assign out_token_last = tlast_q;
	assign out_error_code = err_q;
	assign out_run_last   = rlast_q;

endmodule

// ===== src/sclex_ctrl.sv =====
`timescale 1ns / 1ps
// Lexer controller: input handshake, lexing mode and the token flush sequence.
// Drives sclex_dp through dp_cmd_t and reads dp_status_t. Uses sclex_pkg.
module sclex_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  in_action,
	input  sclex_pkg::dp_status_t status,
	output sclex_pkg::dp_cmd_t    cmd
);
	import sclex_pkg::*;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_WORD,
		MODE_NUMBER,
		MODE_TEXT,
		MODE_ERROR
	} lex_mode_t;

	typedef enum logic [1:0] {
		ST_IN,
		ST_DO,
		ST_FLUSH
	} fsm_state_t;

	fsm_state_t state_q, state_d;
	lex_mode_t  mode_q, mode_d;
	logic       act_q, act_d;
	logic [3:0] fl_kind_q, fl_kind_d;
	logic       fl_follow_q, fl_follow_d;
	logic       fl_rl_q, fl_rl_d;

	logic       do_flush;
	logic [3:0] fl_kind;
	logic       fl_follow;
	logic       fl_rl;
	logic       fresh_emits;

	function automatic emit_t mk_emit(logic [3:0] kind, logic has, logic tl,
	                                  logic [2:0] err, logic rl);
		emit_t e;
		e.valid      = 1'b1;
		e.kind       = kind;
		e.has_char   = has;
		e.token_last = tl;
		e.err        = err;
		e.run_last   = rl;
		return e;
	endfunction

	function automatic logic [3:0] punct_kind(char_class_t c);
		logic [3:0] r;
		case (c)
			CC_SEMI:   r = KIND_SEMI;
			CC_POPEN:  r = KIND_POPEN;
			CC_PCLOSE: r = KIND_PCLOSE;
			CC_EQUAL:  r = KIND_EQUAL;
			default:   r = KIND_NAME;
		endcase
		return r;
	endfunction

	// A character that gives a result of its own when seen between tokens
	assign fresh_emits = !(status.cls == CC_SPACE || status.cls == CC_CRLF
		|| status.cls == CC_LETTER || status.cls == CC_DIGIT || status.cls == CC_QUOTE);

	assign in_ready = (state_q == ST_IN);

	// Next state and datapath commands
	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		mode_d      = mode_q;
		act_d       = act_q;
		fl_kind_d   = fl_kind_q;
		fl_follow_d = fl_follow_q;
		fl_rl_d     = fl_rl_q;
		do_flush    = 1'b0;
		fl_kind     = KIND_NAME;
		fl_follow   = 1'b0;
		fl_rl       = 1'b1;

		case (state_q)
			ST_IN: begin
				if (in_valid) begin
					cmd.load_char = 1'b1;
					act_d         = in_action;
					state_d       = ST_DO;
				end
			end

			ST_DO: begin
				if (act_q) begin
					// End of source: flush, report open quote, then reset
					case (mode_q)
						MODE_WORD: begin
							do_flush = 1'b1;
							fl_kind  = KIND_NAME;
						end
						MODE_NUMBER: begin
							do_flush = 1'b1;
							fl_kind  = KIND_NUMBER;
						end
						MODE_TEXT: begin
							if (status.out_free) begin
								cmd.emit  = mk_emit(KIND_NAME, 1'b0, 1'b1, ERR_NO_QUOTE, 1'b1);
								cmd.clear = 1'b1;
								mode_d    = MODE_IDLE;
								state_d   = ST_IN;
							end
						end
						default: begin
							cmd.clear = 1'b1;
							mode_d    = MODE_IDLE;
							state_d   = ST_IN;
						end
					endcase
				end else begin
					case (mode_q)
						MODE_ERROR: begin
							state_d = ST_IN;
						end
						MODE_TEXT: begin
							if (status.cls == CC_QUOTE) begin
								do_flush = 1'b1;
								fl_kind  = KIND_TEXT;
							end else if (status.cls == CC_CRLF || status.full) begin
								if (status.out_free) begin
									cmd.emit  = mk_emit(KIND_NAME, 1'b0, 1'b1,
										(status.cls == CC_CRLF) ? ERR_LINEBRK : ERR_TOO_LONG, 1'b1);
									cmd.clear = 1'b1;
									mode_d    = MODE_ERROR;
									state_d   = ST_IN;
								end
							end else begin
								cmd.append = 1'b1;
								state_d    = ST_IN;
							end
						end
						MODE_WORD, MODE_NUMBER: begin
							if ((mode_q == MODE_NUMBER && status.cls == CC_DIGIT)
								|| (mode_q == MODE_WORD && (status.cls == CC_LETTER
								|| status.cls == CC_DIGIT || status.cls == CC_DASH))) begin
								if (!status.full) begin
									cmd.append = 1'b1;
									state_d    = ST_IN;
								end else if (status.out_free) begin
									cmd.emit  = mk_emit(KIND_NAME, 1'b0, 1'b1, ERR_TOO_LONG, 1'b1);
									cmd.clear = 1'b1;
									mode_d    = MODE_ERROR;
									state_d   = ST_IN;
								end
							end else begin
								// Token ends; the character is handled again afterwards
								do_flush  = 1'b1;
								fl_kind   = (mode_q == MODE_WORD) ? KIND_NAME : KIND_NUMBER;
								fl_follow = 1'b1;
								fl_rl     = !fresh_emits;
							end
						end
						default: begin
							// Between tokens
							case (status.cls)
								CC_SPACE, CC_CRLF: begin
									state_d = ST_IN;
								end
								CC_LETTER: begin
									cmd.append = 1'b1;
									mode_d     = MODE_WORD;
									state_d    = ST_IN;
								end
								CC_DIGIT: begin
									cmd.append = 1'b1;
									mode_d     = MODE_NUMBER;
									state_d    = ST_IN;
								end
								CC_QUOTE: begin
									mode_d  = MODE_TEXT;
									state_d = ST_IN;
								end
								CC_SEMI, CC_POPEN, CC_PCLOSE, CC_EQUAL: begin
									if (status.out_free) begin
										cmd.emit = mk_emit(punct_kind(status.cls), 1'b0, 1'b1,
											ERR_NONE, 1'b1);
										state_d  = ST_IN;
									end
								end
								default: begin
									if (status.out_free) begin
										cmd.emit  = mk_emit(KIND_NAME, 1'b0, 1'b1, ERR_UNKNOWN, 1'b1);
										cmd.clear = 1'b1;
										mode_d    = MODE_ERROR;
										state_d   = ST_IN;
									end
								end
							endcase
						end
					endcase
				end
			end

			ST_FLUSH: begin
				// Emit one text word per cycle while the output is free
				if (status.out_free) begin
					cmd.emit = mk_emit(fl_kind_q, 1'b1, status.last_char, ERR_NONE,
						status.last_char && fl_rl_q);
					if (status.last_char) begin
						cmd.clear = 1'b1;
						mode_d    = MODE_IDLE;
						state_d   = fl_follow_q ? ST_DO : ST_IN;
					end else begin
						cmd.rd_next = 1'b1;
					end
				end
			end

			default: begin
				state_d = ST_IN;
			end
		endcase

		// Start a flush: keyword or empty text is one word, otherwise walk the text
		if (do_flush) begin
			if ((fl_kind == KIND_NAME && status.kw_hit) || status.len_zero) begin
				if (status.out_free) begin
					cmd.emit  = mk_emit(status.kw_hit ? status.kw_kind : fl_kind, 1'b0, 1'b1,
						ERR_NONE, fl_rl);
					cmd.clear = 1'b1;
					mode_d    = MODE_IDLE;
					state_d   = fl_follow ? ST_DO : ST_IN;
				end
			end else begin
				cmd.rd_start = 1'b1;
				fl_kind_d    = fl_kind;
				fl_follow_d  = fl_follow;
				fl_rl_d      = fl_rl;
				state_d      = ST_FLUSH;
			end
		end
	end

	// Hold state, mode and flush settings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IN;
			mode_q      <= MODE_IDLE;
			act_q       <= 1'b0;
			fl_kind_q   <= KIND_NAME;
			fl_follow_q <= 1'b0;
			fl_rl_q     <= 1'b0;
		end else begin
			state_q     <= state_d;
			mode_q      <= mode_d;
			act_q       <= act_d;
			fl_kind_q   <= fl_kind_d;
			fl_follow_q <= fl_follow_d;
			fl_rl_q     <= fl_rl_d;
		end
	end

endmodule

// ===== src/source_char_lexer.sv =====
`timescale 1ns / 1ps
// Character-serial lexer top level; uses sclex_pkg, sclex_ctrl and sclex_dp.
// A character is taken in the input state and decoded in the state after it, which
// registers its first result word; a walked text token registers its first word from the
// flush state. No character is taken before the last is decoded; a walked token emits one
// word per text character, a keyword one word, and the ending character is decoded again.
// Reset (arst_n low) clears mode, text length and output valid at once; no clearing pass.
module source_char_lexer #(
	parameter int MAX_TOKEN_LEN = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] char_in
	input  logic [0:0]  s_axis_tuser,  // [0] action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [7:0] text_char, [12:8] char_index,
	                                   // [13] token_last, [16:14] error_code, zero fill
	output logic [4:0]  m_axis_tuser,  // [3:0] token_kind, [4] has_char
	output logic        m_axis_tlast   // run_last
);
	import sclex_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;
	logic [3:0] out_kind;
	logic       out_has_char;
	logic [7:0] out_text_char;
	logic [4:0] out_char_index;
	logic       out_token_last;
	logic [2:0] out_error_code;
	logic       out_run_last;

	sclex_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_action (s_axis_tuser[0]),
		.status    (status),
		.cmd       (cmd)
	);

	sclex_dp #(
		.MAX_TOKEN_LEN (MAX_TOKEN_LEN)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_char        (s_axis_tdata),
		.cmd            (cmd),
		.status         (status),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_kind       (out_kind),
		.out_has_char   (out_has_char),
		.out_text_char  (out_text_char),
		.out_char_index (out_char_index),
		.out_token_last (out_token_last),
		.out_error_code (out_error_code),
		.out_run_last   (out_run_last)
	);

	// Pack the result word
	assign m_axis_tdata = {7'd0, out_error_code, out_token_last, out_char_index, out_text_char};
	assign m_axis_tuser = {out_has_char, out_kind};
	assign m_axis_tlast = out_run_last;

endmodule

// ===== verif/source_char_lexer_chk.sv =====
`timescale 1ns / 1ps
// Checker for the source character lexer: predicts the token words from every
// accepted input word and compares them with the accepted output words.
// Depends on sclex_pkg for the token kind and error codes.
module source_char_lexer_chk
	import sclex_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] char_in
	input  logic [0:0]  s_axis_tuser,  // [0] action
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,  // [7:0] text_char, [12:8] char_index,
	                                   // [13] token_last, [16:14] error_code, zero fill
	input  logic [4:0]  m_axis_tuser,  // [3:0] token_kind, [4] has_char
	input  logic        m_axis_tlast,  // run_last
	output int          fail_count,
	output int          pending
);

	localparam int TEXT_DEPTH = 32;
	localparam logic [0:0] ACT_CHAR = 1'b0;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef enum logic [2:0] {
		LM_IDLE,
		LM_WORD,
		LM_NUMBER,
		LM_TEXT,
		LM_ERROR
	} lex_mode_e;

	typedef struct packed {
		logic [3:0] kind;
		logic       has_char;
		logic [7:0] text_char;
		logic [4:0] char_index;
		logic       token_last;
		logic [2:0] error_code;
		logic       run_last;
	} token_word_t;

	string       keywords [5] = '{"exit", "print", "const", "int", "string"};
	lex_mode_e   mode;
	logic [7:0]  text_buf [TEXT_DEPTH];
	int          text_len;
	token_word_t token_q [$];

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	// Character classes, ASCII only
	function automatic bit is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_space(logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic bit is_word_char(logic [7:0] c);
		return is_letter(c) || is_digit(c) || c == "_" || c == "-";
	endfunction

	function automatic void push_word(logic [3:0] kind, logic has, logic [7:0] ch,
	                                  logic [4:0] idx, logic tlast, logic [2:0] err);
		token_word_t w;
		w.kind       = kind;
		w.has_char   = has;
		w.text_char  = ch;
		w.char_index = idx;
		w.token_last = tlast;
		w.error_code = err;
		w.run_last   = 1'b0;
		token_q.insert(token_q.size(), w);
	endfunction

	function automatic void raise_error(logic [2:0] err);
		mode     = LM_ERROR;
		text_len = 0;
		push_word(KIND_NAME, 1'b0, 8'h00, 5'd0, 1'b1, err);
	endfunction

	// Keyword kind of the buffered word, or KIND_NAME when it is none
	function automatic logic [3:0] keyword_of();
		bit hit;
		for (int k = 0; k < 5; k++) begin
			hit = (text_len == keywords[k].len());
			for (int i = 0; i < text_len && hit; i++)
				if (text_buf[i] != keywords[k][i])
					hit = 1'b0;
			if (hit)
				return 4'(KIND_EXIT + k);
		end
		return KIND_NAME;
	endfunction

	function automatic bit buf_append(logic [7:0] c);
		if (text_len >= TEXT_DEPTH)
			return 1'b0;
		text_buf[text_len] = c;
		text_len++;
		return 1'b1;
	endfunction

	// Emit the buffered token: one word for a keyword or empty text, else one word per text character
	function automatic void flush_text(logic [3:0] kind);
		logic [3:0] kw;
		if (kind == KIND_NAME) begin
			kw = keyword_of();
			if (kw != KIND_NAME) begin
				text_len = 0;
				push_word(kw, 1'b0, 8'h00, 5'd0, 1'b1, ERR_NONE);
				return;
			end
		end
		if (text_len == 0)
			push_word(kind, 1'b0, 8'h00, 5'd0, 1'b1, ERR_NONE);
		for (int i = 0; i < text_len; i++)
			push_word(kind, 1'b1, text_buf[i], 5'(i), (i + 1 == text_len), ERR_NONE);
		text_len = 0;
	endfunction

	function automatic void lex_char(logic [7:0] c);
		if (mode == LM_ERROR)
			return;
		if (mode == LM_TEXT) begin
			if (c == CH_QUOTE) begin
				flush_text(KIND_TEXT);
				mode = LM_IDLE;
			end else if (c == CH_LF || c == CH_CR) begin
				raise_error(ERR_LINEBRK);
			end else if (!buf_append(c)) begin
				raise_error(ERR_TOO_LONG);
			end
			return;
		end
		// A word or number either grows or ends and hands the character on
		if (mode == LM_WORD) begin
			if (is_word_char(c)) begin
				if (!buf_append(c))
					raise_error(ERR_TOO_LONG);
				return;
			end
			flush_text(KIND_NAME);
		end else if (mode == LM_NUMBER) begin
			if (is_digit(c)) begin
				if (!buf_append(c))
					raise_error(ERR_TOO_LONG);
				return;
			end
			flush_text(KIND_NUMBER);
		end
		mode     = LM_IDLE;
		text_len = 0;
		if (is_space(c))
			return;
		if (is_letter(c) || c == "_") begin
			mode = LM_WORD;
			void'(buf_append(c));
		end else if (is_digit(c)) begin
			mode = LM_NUMBER;
			void'(buf_append(c));
		end else if (c == CH_QUOTE) begin
			mode = LM_TEXT;
		end else if (c == ";") begin
			push_word(KIND_SEMI, 1'b0, 8'h00, 5'd0, 1'b1, ERR_NONE);
		end else if (c == "(") begin
			push_word(KIND_POPEN, 1'b0, 8'h00, 5'd0, 1'b1, ERR_NONE);
		end else if (c == ")") begin
			push_word(KIND_PCLOSE, 1'b0, 8'h00, 5'd0, 1'b1, ERR_NONE);
		end else if (c == "=") begin
			push_word(KIND_EQUAL, 1'b0, 8'h00, 5'd0, 1'b1, ERR_NONE);
		end else begin
			raise_error(ERR_UNKNOWN);
		end
	endfunction

	function automatic void lex_end();
		if (mode == LM_WORD)
			flush_text(KIND_NAME);
		else if (mode == LM_NUMBER)
			flush_text(KIND_NUMBER);
		else if (mode == LM_TEXT)
			raise_error(ERR_NO_QUOTE);
		mode     = LM_IDLE;
		text_len = 0;
	endfunction

	// Predict all words caused by one input word; mark the last of the run
	function automatic void predict_tokens(logic [0:0] act, logic [7:0] c);
		int n0;
		n0 = token_q.size();
		if (act == ACT_CHAR)
			lex_char(c);
		else
			lex_end();
		if (token_q.size() > n0)
			token_q[token_q.size() - 1].run_last = 1'b1;
	endfunction

	function automatic int field_bad(string name, logic [7:0] exp_v, logic [7:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
			return 1;
		end
		return 0;
	endfunction

	// Track input words, then compare each output word with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : scoreboard
		token_word_t exp_w;
		int          bad;
		if (!arst_n) begin
			mode     = LM_IDLE;
			text_len = 0;
			token_q.delete();
			pending <= 0;
		end else begin
			bad = 0;
			if (s_axis_tvalid && s_axis_tready)
				predict_tokens(s_axis_tuser, s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (token_q.size() == 0) begin
					$error("token word with no prediction: tuser %h tdata %h",
					       m_axis_tuser, m_axis_tdata);
					bad++;
				end else begin
					exp_w = token_q.pop_front();
					bad += field_bad("token_kind", 8'(exp_w.kind), 8'(m_axis_tuser[3:0]));
					bad += field_bad("has_char", 8'(exp_w.has_char), 8'(m_axis_tuser[4]));
					bad += field_bad("text_char", exp_w.text_char, m_axis_tdata[7:0]);
					bad += field_bad("char_index", 8'(exp_w.char_index),
					                 8'(m_axis_tdata[12:8]));
					bad += field_bad("token_last", 8'(exp_w.token_last), 8'(m_axis_tdata[13]));
					bad += field_bad("error_code", 8'(exp_w.error_code),
					                 8'(m_axis_tdata[16:14]));
					bad += field_bad("run_last", 8'(exp_w.run_last), 8'(m_axis_tlast));
				end
			end
			if (bad != 0)
				fail_count <= fail_count + bad;
			pending <= token_q.size();
		end
	end

endmodule

// ===== verif/source_char_lexer_tb.sv =====
`timescale 1ns / 1ps
// Top of the lexer testbench: clock, reset, source characters and receiver stalls.
// Depends on sclex_pkg, source_char_lexer and source_char_lexer_chk.
module source_char_lexer_tb;
	import sclex_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_CYCLES  = 40;
	localparam int RANDOM_ITEMS  = 8;
	localparam int TOKEN_MAX     = 32;
	localparam logic [0:0] ACT_CHAR = 1'b0;
	localparam logic [0:0] ACT_END  = 1'b1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic [0:0]  s_tuser = ACT_CHAR;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [4:0]  m_tuser;
	logic        m_tlast;

	int    chk_fails;
	int    chk_pending;
	int    cycle_cnt = 0;
	int    src_idle = 0;
	int    snk_idle = 0;
	int    items_sent = 0;
	int    hold_cnt = 0;
	logic  hold_req = 1'b0;
	string keywords [5] = '{"exit", "print", "const", "int", "string"};
	string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-";
	string space_chars = " \t\n\r\v\f";
	string punct_chars = ";()=";

	source_char_lexer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser),
		.m_axis_tlast  (m_tlast)
	);

	source_char_lexer_chk u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser),
		.m_axis_tlast  (m_tlast),
		.fail_count    (chk_fails),
		.pending       (chk_pending)
	);

	always #6 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver: random stalls, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			m_tready <= 1'b0;
			hold_cnt <= hold_cnt - 1;
		end else if (hold_req) begin
			m_tready <= 1'b0;
			hold_cnt <= HOLD_CYCLES;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= snk_idle);
		end
	end

	// Offer one word and hold it until accepted; valid stays high into the next word
	task automatic send(logic [0:0] act, logic [7:0] ch);
		while ($urandom_range(0, 99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tuser  <= act;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_str(string s);
		for (int i = 0; i < s.len(); i++)
			send(ACT_CHAR, s[i]);
	endtask

	task automatic send_end();
		send(ACT_END, 8'($urandom_range(0, 255)));
	endtask

	// Drop valid and wait until every predicted word has come out
	task automatic wait_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (chk_pending != 0)
			@(posedge clk);
	endtask

	task automatic send_word(int len);
		send(ACT_CHAR, word_chars[$urandom_range(0, 51)]);
		for (int i = 1; i < len; i++)
			send(ACT_CHAR, word_chars[$urandom_range(0, word_chars.len() - 1)]);
	endtask

	function automatic logic [7:0] text_byte();
		logic [7:0] c;
		if ($urandom_range(0, 99) < 80) begin
			c = 8'($urandom_range(8'h20, 8'h7E));
			if (c == 8'h22)
				c = "q";
		end else begin
			do
				c = 8'($urandom_range(0, 255));
			while (c == 8'h22 || c == 8'h0A || c == 8'h0D);
		end
		return c;
	endfunction

	task automatic send_text(int len);
		send(ACT_CHAR, 8'h22);
		for (int i = 0; i < len; i++)
			send(ACT_CHAR, text_byte());
	endtask

	// One random token, mostly well formed, some noise and broken input
	task automatic send_token();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			send_str(keywords[$urandom_range(0, 4)]);
			if ($urandom_range(0, 1))
				send(ACT_CHAR, " ");
		end else if (r < 33) begin
			send_word($urandom_range(1, 6));
			if ($urandom_range(0, 1))
				send(ACT_CHAR, " ");
		end else if (r < 46) begin
			for (int i = $urandom_range(1, 5); i > 0; i--)
				send(ACT_CHAR, 8'($urandom_range("0", "9")));
		end else if (r < 58) begin
			send_text($urandom_range(0, 6));
			send(ACT_CHAR, 8'h22);
		end else if (r < 74) begin
			send(ACT_CHAR, punct_chars[$urandom_range(0, 3)]);
		end else if (r < 82) begin
			send(ACT_CHAR, space_chars[$urandom_range(0, space_chars.len() - 1)]);
		end else if (r < 89) begin
			send_end();
		end else if (r < 94) begin
			send(ACT_CHAR, 8'($urandom_range(0, 255)));
			if ($urandom_range(0, 99) < 70)
				send_end();
		end else begin
			// unterminated or broken text
			send_text($urandom_range(0, 4));
			if ($urandom_range(0, 1))
				send(ACT_CHAR, $urandom_range(0, 1) ? 8'h0A : 8'h0D);
			send_end();
		end
	endtask

	task automatic random_phase();
		int start;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS)
			send_token();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Phase one: sender idles a quarter, receiver three quarters
		src_idle = 25;
		snk_idle <= 75;

		// Name and number ended by punctuation, empty text, parentheses
		send_str("x=90;\"\"()\"");
		// High and zero bytes are plain text inside quotes
		send(ACT_CHAR, 8'hFF);
		send(ACT_CHAR, 8'h00);
		send(ACT_CHAR, 8'h22);
		// High byte outside quotes, then ignored input up to end of source
		send(ACT_CHAR, 8'hFF);
		send(ACT_CHAR, "a");
		send(ACT_END, 8'hFF);
		// Line break in quotes, missing closing quote, zero byte outside quotes
		send_str("\"\n");
		send(ACT_END, 8'h00);
		send_str("\"q");
		send_end();
		send(ACT_CHAR, 8'h00);
		send_end();
		// Pending word flushed by end of source, and end of source while idle
		send(ACT_CHAR, "A");
		send_end();
		send_end();

		random_phase();

		// Long receiver hold-off while a full-length word and an overlong text go in
		send_end();
		hold_req <= 1'b1;
		s_tvalid <= 1'b0;
		@(posedge clk);
		hold_req <= 1'b0;
		send_word(TOKEN_MAX);
		send(ACT_CHAR, "=");
		send_text(TOKEN_MAX + 1);
		send_end();
		wait_drain();

		// Phase two: sender idles three quarters, receiver a quarter
		src_idle = 75;
		snk_idle <= 25;
		random_phase();

		// Phase three: no idling on either side
		src_idle = 0;
		snk_idle <= 0;
		random_phase();
		send_end();

		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (chk_fails == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
